[rtl/core/btsd_pkg.sv]
// Package for the tokenized BASIC detokenizer: types, constants and the keyword ROM.
`default_nettype none
package btsd_pkg;

  localparam int unsigned AddrWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned KwChars   = 7;

  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChApos    = 8'h27;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] TokRem    = 8'h8E;
  localparam logic [7:0] TokFf     = 8'hFF;
  localparam logic [7:0] TokElse   = 8'h91;

  typedef enum logic [2:0] {
    PH_LINK_LO, PH_LINK_HI, PH_NUM_LO, PH_NUM_HI, PH_BODY, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    LA_NONE, LA_COLON, LA_COLON_8E
  } look_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHAR, S_TAKE, S_KW, S_DEC, S_NEXT, S_FINISH
  } state_t;

  // Decimal weight of digit position 0 (ten thousands) to 4 (units).
  function automatic logic [15:0] dec_weight(input logic [2:0] pos);
    logic [15:0] w;
    unique case (pos)
      3'd0:    w = 16'd10000;
      3'd1:    w = 16'd1000;
      3'd2:    w = 16'd100;
      3'd3:    w = 16'd10;
      default: w = 16'd1;
    endcase
    return w;
  endfunction

  // Keyword text, right-justified, zero bytes in front; entry 127 is empty.
  function automatic logic [KwChars*8-1:0] kw_word(input logic [6:0] idx);
    logic [KwChars*8-1:0] w;
    unique case (idx)
      7'd0:   w = "END";     7'd1:   w = "FOR";     7'd2:   w = "NEXT";
      7'd3:   w = "DATA";    7'd4:   w = "INPUT";   7'd5:   w = "DIM";
      7'd6:   w = "READ";    7'd7:   w = "LET";     7'd8:   w = "GOTO";
      7'd9:   w = "RUN";     7'd10:  w = "IF";      7'd11:  w = "RESTORE";
      7'd12:  w = "GOSUB";   7'd13:  w = "RETURN";  7'd14:  w = "REM";
      7'd15:  w = "STOP";    7'd16:  w = "WIDTH";   7'd17:  w = "ELSE";
      7'd18:  w = "LINE";    7'd19:  w = "EDIT";    7'd20:  w = "ERROR";
      7'd21:  w = "RESUME";  7'd22:  w = "OUT";     7'd23:  w = "ON";
      7'd24:  w = "DSKO$";   7'd25:  w = "OPEN";    7'd26:  w = "CLOSE";
      7'd27:  w = "LOAD";    7'd28:  w = "MERGE";   7'd29:  w = "FILES";
      7'd30:  w = "SAVE";    7'd31:  w = "LFILES";  7'd32:  w = "LPRINT";
      7'd33:  w = "DEF";     7'd34:  w = "POKE";    7'd35:  w = "PRINT";
      7'd36:  w = "CONT";    7'd37:  w = "LIST";    7'd38:  w = "LLIST";
      7'd39:  w = "CLEAR";   7'd40:  w = "CLOAD";   7'd41:  w = "CSAVE";
      7'd42:  w = "TIME$";   7'd43:  w = "DATE$";   7'd44:  w = "DAY$";
      7'd45:  w = "COM";     7'd46:  w = "MDM";     7'd47:  w = "KEY";
      7'd48:  w = "CLS";     7'd49:  w = "BEEP";    7'd50:  w = "SOUND";
      7'd51:  w = "LCOPY";   7'd52:  w = "PSET";    7'd53:  w = "PRESET";
      7'd54:  w = "MOTOR";   7'd55:  w = "MAX";     7'd56:  w = "POWER";
      7'd57:  w = "CALL";    7'd58:  w = "MENU";    7'd59:  w = "IPL";
      7'd60:  w = "NAME";    7'd61:  w = "KILL";    7'd62:  w = "SCREEN";
      7'd63:  w = "NEW";     7'd64:  w = "TAB(";    7'd65:  w = "TO";
      7'd66:  w = "USING";   7'd67:  w = "VARPTR";  7'd68:  w = "ERL";
      7'd69:  w = "ERR";     7'd70:  w = "STRING$"; 7'd71:  w = "INSTR";
      7'd72:  w = "DSKI$";   7'd73:  w = "INKEY$";  7'd74:  w = "CSRLIN";
      7'd75:  w = "OFF";     7'd76:  w = "HIMEM";   7'd77:  w = "THEN";
      7'd78:  w = "NOT";     7'd79:  w = "STEP";    7'd80:  w = "+";
      7'd81:  w = "-";       7'd82:  w = "*";       7'd83:  w = "/";
      7'd84:  w = "^";       7'd85:  w = "AND";     7'd86:  w = "OR";
      7'd87:  w = "XOR";     7'd88:  w = "EQV";     7'd89:  w = "IMP";
      7'd90:  w = "MOD";     7'd91:  w = "\\";      7'd92:  w = ">";
      7'd93:  w = "=";       7'd94:  w = "<";       7'd95:  w = "SGN";
      7'd96:  w = "INT";     7'd97:  w = "ABS";     7'd98:  w = "FRE";
      7'd99:  w = "INP";     7'd100: w = "LPOS";    7'd101: w = "POS";
      7'd102: w = "SQR";     7'd103: w = "RND";     7'd104: w = "LOG";
      7'd105: w = "EXP";     7'd106: w = "COS";     7'd107: w = "SIN";
      7'd108: w = "TAN";     7'd109: w = "ATN";     7'd110: w = "PEEK";
      7'd111: w = "EOF";     7'd112: w = "LOC";     7'd113: w = "LOF";
      7'd114: w = "CINT";    7'd115: w = "CSNG";    7'd116: w = "CDBL";
      7'd117: w = "FIX";     7'd118: w = "LEN";     7'd119: w = "STR$";
      7'd120: w = "VAL";     7'd121: w = "ASC";     7'd122: w = "CHR$";
      7'd123: w = "SPACE$";  7'd124: w = "LEFT$";   7'd125: w = "RIGHT$";
      7'd126: w = "MID$";
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/core/basic_token_stream_detokenizer_core.sv]
// Top level of the tokenized BASIC detokenizer: byte parser and listing text generator.
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata = in_byte
// m_*       out  m_tvalid / m_tready    m_tdata = out_char, m_tlast = last_of_run
// cfg_*     in   cfg_we                 cfg_wdata = base_address
//
// A request that prints nothing passes the steps accept, parse, step and finish; a colon
// waits on its next byte. A keyword's 7-byte ROM word is walked one byte a cycle, holding
// while the output is stalled. A line number is converted by peeling decimal digits
// through one shared compare/subtract unit.
// s_tready is high only while the sequencer idles.
// Reset (synchronous) restarts the parse at address 0; a configuration write restarts it at the base.
// A stalled output holds its character; the sequencer waits until it drains.
module basic_token_stream_detokenizer_core
  import btsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_char
  output logic             m_tlast,   // last_of_run
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata  // [15:0] base_address
);

  state_t state, state_next;
  phase_t phase, phase_next;
  look_t  look, look_next;

  logic [15:0] cur_addr, cur_addr_next;
  logic [15:0] link, link_next;
  logic [15:0] line_num, line_num_next;

  // Bytes still to be parsed for this request, and the character to print.
  logic [7:0]  cur, cur_next;
  logic [7:0]  second, second_next;
  logic        has_second, has_second_next;
  logic        take_pending, take_pending_next;
  logic [7:0]  ch, ch_next;

  // Keyword shift register and decimal conversion registers.
  logic [KwChars*8-1:0] word, word_next;
  logic [15:0] dec_val, dec_val_next;
  logic [3:0]  digit, digit_next;
  logic [2:0]  dec_pos, dec_pos_next;
  logic        started, started_next;

  // One character is held back so that the last one of a request can be marked.
  logic        pend_valid;
  logic [7:0]  pend;

  logic        accept;
  logic        can_push;
  logic        emit_ok;
  logic        emit_req;
  logic [7:0]  emit_val;
  logic        flush_req;
  logic [7:0]  kw_top;
  logic        dec_ge;
  logic        dec_show;
  logic [15:0] weight;
  logic        at_end;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_push = !m_tvalid || m_tready;
  assign emit_ok  = !pend_valid || can_push;
  assign kw_top   = word[KwChars*8-1 -: 8];
  assign weight   = dec_weight(dec_pos);
  assign dec_ge   = (dec_val >= weight);
  assign dec_show = (digit != 4'd0) || started || (dec_pos == 3'd4);
  assign at_end   = (cur_addr >= link);

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (look == LA_COLON) begin
            if (s_tdata == TokRem) state_next = S_FINISH;
            else if (s_tdata == TokElse) state_next = S_TAKE;
            else state_next = S_CHAR;
          end else if (look == LA_COLON_8E) begin
            state_next = S_CHAR;
          end else begin
            state_next = S_TAKE;
          end
        end
      end
      S_CHAR: begin
        if (emit_ok) state_next = take_pending ? S_TAKE : S_NEXT;
      end
      S_TAKE: begin
        state_next = S_NEXT;
        unique case (phase)
          PH_NUM_HI: state_next = S_DEC;
          PH_BODY: begin
            if (!at_end && cur != ChColon) begin
              state_next = cur[7] ? S_KW : S_CHAR;
            end
          end
          default: state_next = S_NEXT;
        endcase
      end
      S_KW: begin
        if (word == '0) state_next = S_NEXT;
      end
      S_DEC: begin
        if (!dec_ge && dec_show && emit_ok && dec_pos == 3'd4) state_next = S_CHAR;
      end
      S_NEXT: begin
        state_next = has_second ? S_TAKE : S_FINISH;
      end
      S_FINISH: begin
        if (!pend_valid || can_push) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath updates and character requests.
  always_comb begin
    phase_next        = phase;
    look_next         = look;
    cur_addr_next     = cur_addr;
    link_next         = link;
    line_num_next     = line_num;
    cur_next          = cur;
    second_next       = second;
    has_second_next   = has_second;
    take_pending_next = take_pending;
    ch_next           = ch;
    word_next         = word;
    dec_val_next      = dec_val;
    digit_next        = digit;
    dec_pos_next      = dec_pos;
    started_next      = started;
    emit_req          = 1'b0;
    emit_val          = ch;
    flush_req         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next = s_tdata;
          if (look == LA_COLON) begin
            if (s_tdata == TokRem) begin
              look_next = LA_COLON_8E;
            end else begin
              look_next         = LA_NONE;
              ch_next           = ChColon;
              take_pending_next = 1'b1;
            end
          end else if (look == LA_COLON_8E) begin
            look_next = LA_NONE;
            if (s_tdata == TokFf) begin
              ch_next           = ChApos;
              take_pending_next = 1'b0;
              cur_addr_next     = cur_addr + 16'd2;
            end else begin
              ch_next           = ChColon;
              cur_next          = TokRem;
              second_next       = s_tdata;
              has_second_next   = 1'b1;
              take_pending_next = 1'b1;
            end
          end
        end
      end
      S_CHAR: begin
        emit_req = 1'b1;
        emit_val = ch;
      end
      S_TAKE: begin
        take_pending_next = 1'b0;
        unique case (phase)
          PH_LINK_LO: begin
            link_next     = {8'd0, cur};
            phase_next    = PH_LINK_HI;
            cur_addr_next = cur_addr + 16'd1;
          end
          PH_LINK_HI: begin
            link_next     = {cur, link[7:0]};
            cur_addr_next = cur_addr + 16'd1;
            phase_next    = ({cur, link[7:0]} != 16'd0) ? PH_NUM_LO : PH_DONE;
          end
          PH_NUM_LO: begin
            line_num_next = {8'd0, cur};
            phase_next    = PH_NUM_HI;
            cur_addr_next = cur_addr + 16'd1;
          end
          PH_NUM_HI: begin
            line_num_next = {cur, line_num[7:0]};
            cur_addr_next = cur_addr + 16'd1;
            phase_next    = PH_BODY;
            dec_val_next  = {cur, line_num[7:0]};
            digit_next    = 4'd0;
            dec_pos_next  = 3'd0;
            started_next  = 1'b0;
          end
          PH_BODY: begin
            cur_addr_next = cur_addr + 16'd1;
            if (at_end) begin
              // The line is over: this byte opens the next link.
              link_next  = {8'd0, cur};
              phase_next = PH_LINK_HI;
            end else if (cur == ChColon) begin
              look_next = LA_COLON;
            end else if (cur[7]) begin
              word_next = kw_word(cur[6:0]);
            end else if (cur == 8'd0) begin
              ch_next = ChNewline;
            end else begin
              ch_next = cur;
            end
          end
          default: begin
          end
        endcase
      end
      S_KW: begin
        if (word != '0) begin
          if (kw_top == 8'd0) begin
            word_next = word << 8;
          end else begin
            emit_req = 1'b1;
            emit_val = kw_top;
            if (emit_ok) word_next = word << 8;
          end
        end
      end
      S_DEC: begin
        if (dec_ge) begin
          dec_val_next = dec_val - weight;
          digit_next   = digit + 4'd1;
        end else if (dec_show) begin
          emit_req = 1'b1;
          emit_val = ChZero | {4'd0, digit};
          if (emit_ok) begin
            started_next = 1'b1;
            digit_next   = 4'd0;
            dec_pos_next = dec_pos + 3'd1;
            ch_next      = ChSpace;
          end
        end else begin
          digit_next   = 4'd0;
          dec_pos_next = dec_pos + 3'd1;
        end
      end
      S_NEXT: begin
        if (has_second) begin
          cur_next          = second;
          has_second_next   = 1'b0;
          take_pending_next = 1'b0;
        end
      end
      S_FINISH: begin
        flush_req = pend_valid && can_push;
      end
      default: begin
      end
    endcase
    // A new base restarts the parse from a fresh program.
    if (cfg_we) begin
      cur_addr_next = cfg_wdata;
      phase_next    = PH_LINK_LO;
      look_next     = LA_NONE;
      link_next     = 16'd0;
      line_num_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_LINK_LO;
      look         <= LA_NONE;
      cur_addr     <= 16'd0;
      link         <= 16'd0;
      line_num     <= 16'd0;
      has_second   <= 1'b0;
      take_pending <= 1'b0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      look         <= look_next;
      cur_addr     <= cur_addr_next;
      link         <= link_next;
      line_num     <= line_num_next;
      has_second   <= has_second_next;
      take_pending <= take_pending_next;
      if (emit_req && emit_ok) begin
        if (pend_valid) begin
          m_tvalid <= 1'b1;
          m_tdata  <= pend;
          m_tlast  <= 1'b0;
        end else if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        pend       <= emit_val;
        pend_valid <= 1'b1;
      end else if (flush_req) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= pend;
        m_tlast    <= 1'b1;
        pend_valid <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    second  <= second_next;
    ch      <= ch_next;
    word    <= word_next;
    dec_val <= dec_val_next;
    digit   <= digit_next;
    dec_pos <= dec_pos_next;
    started <= started_next;
  end

endmodule
`default_nettype wire
